FILE: rtl/core/jse_pkg.sv
`default_nettype none

package jse_pkg;

    localparam int SEQ_LEN = 6;
    localparam int CNT_W   = $clog2(SEQ_LEN + 1);

    typedef logic [7:0]       octet_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        KIND_OPEN  = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_CLOSE = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    // octets produced for one item, first octet at index 0
    typedef struct packed {
        cnt_t                    count;
        octet_t [SEQ_LEN-1:0]    octets;
    } seq_t;

    localparam octet_t CH_QUOTE     = 8'h22;
    localparam octet_t CH_BACKSLASH = 8'h5c;
    localparam octet_t CH_ZERO      = 8'h30;
    localparam octet_t CH_LOWER_B   = 8'h62;
    localparam octet_t CH_LOWER_F   = 8'h66;
    localparam octet_t CH_LOWER_N   = 8'h6e;
    localparam octet_t CH_LOWER_R   = 8'h72;
    localparam octet_t CH_LOWER_T   = 8'h74;
    localparam octet_t CH_LOWER_U   = 8'h75;
    localparam octet_t CTRL_LIMIT   = 8'h20;
    localparam octet_t UTF8_LEAD    = 8'hc0;
    localparam octet_t UTF8_CONT    = 8'h80;

    localparam octet_t HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    function automatic octet_t hex_digit(input logic [3:0] nib);
        return HEX_DIGITS[nib];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/jse_ifs.sv
`default_nettype none

interface jse_item_if;
    import jse_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface jse_octet_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/jse_encode.sv
`default_nettype none

module jse_encode
    import jse_pkg::*;
(
    input  wire logic [1:0] kind,
    input  wire logic [7:0] data_byte,
    output seq_t            seq
);

    octet_t short_esc;

    always_comb
    begin
        unique case (data_byte)
            CH_QUOTE:     short_esc = CH_QUOTE;
            CH_BACKSLASH: short_esc = CH_BACKSLASH;
            8'h08:        short_esc = CH_LOWER_B;
            8'h0c:        short_esc = CH_LOWER_F;
            8'h0a:        short_esc = CH_LOWER_N;
            8'h0d:        short_esc = CH_LOWER_R;
            8'h09:        short_esc = CH_LOWER_T;
            default:      short_esc = '0;
        endcase
    end

    always_comb
    begin
        seq.count  = '0;
        seq.octets = '0;
        unique case (kind_t'(kind))
            KIND_OPEN, KIND_CLOSE:
            begin
                seq.count     = cnt_t'(1);
                seq.octets[0] = CH_QUOTE;
            end
            KIND_DATA:
            begin
                priority if (short_esc != '0)
                begin
                    seq.count     = cnt_t'(2);
                    seq.octets[0] = CH_BACKSLASH;
                    seq.octets[1] = short_esc;
                end
                else if (data_byte < CTRL_LIMIT)
                begin
                    seq.count     = cnt_t'(6);
                    seq.octets[0] = CH_BACKSLASH;
                    seq.octets[1] = CH_LOWER_U;
                    seq.octets[2] = CH_ZERO;
                    seq.octets[3] = CH_ZERO;
                    seq.octets[4] = hex_digit(data_byte[7:4]);
                    seq.octets[5] = hex_digit(data_byte[3:0]);
                end
                else if (!data_byte[7])
                begin
                    seq.count     = cnt_t'(1);
                    seq.octets[0] = data_byte;
                end
                else
                begin
                    // two-octet utf-8 form
                    seq.count     = cnt_t'(2);
                    seq.octets[0] = UTF8_LEAD | {6'b0, data_byte[7:6]};
                    seq.octets[1] = UTF8_CONT | {2'b0, data_byte[5:0]};
                end
            end
            default:
            begin
                seq.count = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/jse_out_buf.sv
`default_nettype none

module jse_out_buf
    import jse_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire seq_t       seq,
    output logic            can_load,
    jse_octet_if.source     octets
);

    cnt_t                 count_reg, count_next;
    octet_t [SEQ_LEN-1:0] bytes_reg, bytes_next;
    logic                 pop;

    assign octets.valid       = (count_reg != '0);
    assign octets.out_byte    = bytes_reg[0];
    assign octets.last_of_run = (count_reg == cnt_t'(1));

    assign pop      = octets.valid && octets.ready;
    // free now, or the final word of the run leaves this cycle
    assign can_load = (count_reg == '0) || (pop && count_reg == cnt_t'(1));

    always_comb
    begin
        count_next = count_reg;
        bytes_next = bytes_reg;
        if (load)
        begin
            count_next = seq.count;
            bytes_next = seq.octets;
        end
        else if (pop)
        begin
            count_next = count_reg - cnt_t'(1);
            for (int i = 0; i < SEQ_LEN - 1; i++)
            begin
                bytes_next[i] = bytes_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> can_load)
        else $error("run loaded over words not yet taken");

    a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> octets.valid)
        else $error("loaded run shows no word");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(SEQ_LEN))
        else $error("run length out of range");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !load) |=> (count_reg == $past(count_reg) - cnt_t'(1)))
        else $error("taken word not retired");

endmodule

`default_nettype wire

FILE: rtl/core/json_string_escaper_latin1.sv
// channel   dir   fields                    meaning
// items     in    kind[1:0], data_byte[7:0]  open, data byte, close
// octets    out   out_byte[7:0], last_of_run one utf-8 json octet
//
// an item is registered, encoded in one pass and loaded as a run of 1..6 words
// one word per cycle leaves the run register while octets.ready is high; a run
// holds 1 word for plain bytes and quotes, 2 for short escapes and
// high bytes, 6 for \u00xx; kind 3 is dropped with no word
// items are taken while a finished run still waits on octets.ready
// asynchronous active-low reset empties both registers

`default_nettype none

module json_string_escaper_latin1
    import jse_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    jse_item_if.sink    items,
    jse_octet_if.source octets
);

    logic        hold_valid_reg, hold_valid_next;
    logic [1:0]  kind_reg;
    logic [7:0]  byte_reg;
    seq_t        seq;
    logic        can_load;
    logic        load;
    logic        advance;
    logic        take;

    jse_encode u_encode (
        .kind      (kind_reg),
        .data_byte (byte_reg),
        .seq       (seq)
    );

    jse_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .seq      (seq),
        .can_load (can_load),
        .octets   (octets)
    );

    // an empty run just leaves the input register
    assign advance     = hold_valid_reg && ((seq.count == '0) || can_load);
    assign load        = hold_valid_reg && (seq.count != '0) && can_load;
    assign items.ready = !hold_valid_reg || advance;
    assign take        = items.valid && items.ready;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (advance)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg <= items.kind;
            byte_reg <= items.data_byte;
        end
    end

    a_hold_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && !advance) |=> (hold_valid_reg && $stable(kind_reg)
            && $stable(byte_reg)))
        else $error("held word lost while stalled");

    a_load_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> hold_valid_reg)
        else $error("run loaded with nothing held");

endmodule

`default_nettype wire
